[hw/rtl/pwmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pwmc_pkg;

  // Register reset values.
  localparam logic [15:0] PeriodRst  = 16'd1000;
  localparam logic [6:0]  FloorRst   = 7'd10;
  localparam logic [6:0]  CeilRst    = 7'd100;
  localparam logic [6:0]  OpenRst    = 7'd50;
  localparam logic [6:0]  CloseRst   = 7'd100;
  localparam logic [15:0] TimeoutRst = 16'd1000;

  // Duty is a percentage.
  localparam logic [6:0] FullDuty = 7'd100;

  // Division by 100 as a multiply by floor(2^23 / 100) and one correction step.
  localparam int unsigned RecipShift = 23;
  localparam logic [16:0] Recip      = 17'(((64'd1 << RecipShift)) / 64'd100);

  // Cycles the compare pipeline needs after a register write before its
  // outputs reflect the new settings.
  localparam int unsigned SettleCycles = 3;
  localparam int unsigned SettleW      = $clog2(SettleCycles + 1);

  typedef enum logic [2:0] {
    REG_PERIOD  = 3'd0,
    REG_FLOOR   = 3'd1,
    REG_CEIL    = 3'd2,
    REG_OPEN    = 3'd3,
    REG_CLOSE   = 3'd4,
    REG_TIMEOUT = 3'd5
  } pwmc_reg_e;

  typedef enum logic [2:0] {
    MODE_INIT         = 3'd0,
    MODE_IDLE         = 3'd1,
    MODE_OPENING      = 3'd2,
    MODE_OPENING_AUTO = 3'd3,
    MODE_CLOSING      = 3'd4,
    MODE_CLOSING_AUTO = 3'd5,
    MODE_STOP         = 3'd6,
    MODE_SLEEP        = 3'd7
  } pwmc_mode_e;

  // Settings the compare calculation depends on.
  typedef struct packed {
    logic [15:0] period;
    logic [6:0]  floor_pct;
    logic [6:0]  ceil_pct;
  } pwmc_cmp_cfg_t;

  // Switch levels of one control tick.
  typedef struct packed {
    logic down_sw;
    logic up_sw;
    logic auto_sw;
    logic sleep_req;
    logic wake_req;
  } pwmc_sw_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] down_cmp;
    logic [15:0] up_cmp;
    logic        motor_en;
    logic        pwm_run;
  } pwmc_res_t;

endpackage

`default_nettype wire

[hw/rtl/pwmc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pwmc_in_if;
  logic valid;
  logic ready;
  logic down_switch;
  logic up_switch;
  logic auto_switch;
  logic sleep_request;
  logic wake_request;

  modport source (
    output valid, down_switch, up_switch, auto_switch, sleep_request, wake_request,
    input  ready
  );
  modport sink (
    input  valid, down_switch, up_switch, auto_switch, sleep_request, wake_request,
    output ready
  );
endinterface

interface pwmc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode_code;
  logic [15:0] down_compare_out;
  logic [15:0] up_compare_out;
  logic        motor_enable_out;
  logic        pwm_running_out;

  modport source (
    output valid, mode_code, down_compare_out, up_compare_out, motor_enable_out,
           pwm_running_out,
    input  ready
  );
  modport sink (
    input  valid, mode_code, down_compare_out, up_compare_out, motor_enable_out,
           pwm_running_out,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/pwmc_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none

// Turns a duty percentage into a PWM compare value in three register stages.
module pwmc_cmp (
  input  wire logic                   clk_i,
  input  wire pwmc_pkg::pwmc_cmp_cfg_t cfg_i,
  input  wire logic [6:0]             duty_i,
  output logic [15:0]                 cmp_o
);

  logic [6:0]  duty_max;
  logic [6:0]  duty_clamp;
  logic [6:0]  factor;
  logic        use_period;

  logic [22:0] prod_q;
  logic        use_period1_q;
  logic [39:0] scaled_q;
  logic [22:0] prod2_q;
  logic        use_period2_q;

  logic [16:0] quot_est;
  logic [22:0] quot_times;
  logic [22:0] remainder;
  logic [16:0] quot;
  logic [15:0] cmp_d;
  logic [15:0] cmp_q;

  // Raise to the floor first, then cap at the ceiling, so the ceiling wins.
  always_comb begin
    duty_max   = (duty_i < cfg_i.floor_pct) ? cfg_i.floor_pct : duty_i;
    duty_clamp = (duty_max > cfg_i.ceil_pct) ? cfg_i.ceil_pct : duty_max;
    use_period = (duty_i == 7'd0) || (duty_clamp == 7'd0);
    factor     = (duty_clamp >= pwmc_pkg::FullDuty) ? 7'd0
                                                    : 7'(pwmc_pkg::FullDuty - duty_clamp);
  end

  always_ff @(posedge clk_i) begin
    prod_q        <= 23'(factor) * 23'(cfg_i.period);
    use_period1_q <= use_period;
    scaled_q      <= 40'(prod_q) * 40'(pwmc_pkg::Recip);
    prod2_q       <= prod_q;
    use_period2_q <= use_period1_q;
    cmp_q         <= cmp_d;
  end

  // The estimate is the true quotient or one below it.
  always_comb begin
    quot_est   = 17'(scaled_q >> pwmc_pkg::RecipShift);
    quot_times = (23'(quot_est) << 6) + (23'(quot_est) << 5) + (23'(quot_est) << 2);
    remainder  = prod2_q - quot_times;
    quot       = (remainder >= 23'd100) ? quot_est + 17'd1 : quot_est;
    if (use_period2_q || (quot > {1'b0, cfg_i.period})) begin
      cmp_d = cfg_i.period;
    end else begin
      cmp_d = quot[15:0];
    end
  end

  assign cmp_o = cmp_q;

endmodule

`default_nettype wire

[hw/rtl/pwmc_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none

// Window mode machine and the state it owns. res_o is the state after the
// update that an accepted tick causes.
module pwmc_fsm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire pwmc_pkg::pwmc_sw_t  sw_i,
  input  wire logic [15:0]         brake_cmp_i,
  input  wire logic [15:0]         open_cmp_i,
  input  wire logic [15:0]         close_cmp_i,
  input  wire logic [15:0]         auto_timeout_i,
  output pwmc_pkg::pwmc_res_t      res_o
);

  pwmc_pkg::pwmc_mode_e mode_q, mode_d;
  logic [15:0] auto_cnt_q, auto_cnt_d;
  logic [15:0] down_cmp_q, down_cmp_d;
  logic [15:0] up_cmp_q, up_cmp_d;
  logic        motor_en_q, motor_en_d;
  logic        pwm_run_q, pwm_run_d;
  logic        opposite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= pwmc_pkg::MODE_INIT;
      auto_cnt_q <= '0;
      down_cmp_q <= '0;
      up_cmp_q   <= '0;
      motor_en_q <= 1'b0;
      pwm_run_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      auto_cnt_q <= auto_cnt_d;
      down_cmp_q <= down_cmp_d;
      up_cmp_q   <= up_cmp_d;
      motor_en_q <= motor_en_d;
      pwm_run_q  <= pwm_run_d;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    auto_cnt_d = auto_cnt_q;
    down_cmp_d = down_cmp_q;
    up_cmp_d   = up_cmp_q;
    motor_en_d = motor_en_q;
    pwm_run_d  = pwm_run_q;
    opposite   = (mode_q == pwmc_pkg::MODE_OPENING_AUTO) ? sw_i.up_sw : sw_i.down_sw;

    case (mode_q)
      pwmc_pkg::MODE_INIT: begin
        motor_en_d = 1'b1;
        pwm_run_d  = 1'b1;
        down_cmp_d = brake_cmp_i;
        up_cmp_d   = brake_cmp_i;
        mode_d     = pwmc_pkg::MODE_IDLE;
      end
      pwmc_pkg::MODE_IDLE: begin
        if (sw_i.sleep_req) begin
          motor_en_d = 1'b0;
          pwm_run_d  = 1'b0;
          mode_d     = pwmc_pkg::MODE_SLEEP;
        end else if (sw_i.down_sw && !sw_i.up_sw) begin
          down_cmp_d = open_cmp_i;
          up_cmp_d   = brake_cmp_i;
          if (sw_i.auto_sw) begin
            auto_cnt_d = auto_timeout_i;
            mode_d     = pwmc_pkg::MODE_OPENING_AUTO;
          end else begin
            mode_d = pwmc_pkg::MODE_OPENING;
          end
        end else if (sw_i.up_sw && !sw_i.down_sw) begin
          down_cmp_d = brake_cmp_i;
          up_cmp_d   = close_cmp_i;
          if (sw_i.auto_sw) begin
            auto_cnt_d = auto_timeout_i;
            mode_d     = pwmc_pkg::MODE_CLOSING_AUTO;
          end else begin
            mode_d = pwmc_pkg::MODE_CLOSING;
          end
        end
      end
      pwmc_pkg::MODE_OPENING: begin
        if (!sw_i.down_sw || sw_i.up_sw) begin
          down_cmp_d = brake_cmp_i;
          up_cmp_d   = brake_cmp_i;
          mode_d     = pwmc_pkg::MODE_STOP;
        end
      end
      pwmc_pkg::MODE_CLOSING: begin
        if (!sw_i.up_sw || sw_i.down_sw) begin
          down_cmp_d = brake_cmp_i;
          up_cmp_d   = brake_cmp_i;
          mode_d     = pwmc_pkg::MODE_STOP;
        end
      end
      pwmc_pkg::MODE_OPENING_AUTO, pwmc_pkg::MODE_CLOSING_AUTO: begin
        if ((auto_cnt_q == 16'd0) || !sw_i.auto_sw || opposite) begin
          auto_cnt_d = '0;
          down_cmp_d = brake_cmp_i;
          up_cmp_d   = brake_cmp_i;
          mode_d     = pwmc_pkg::MODE_STOP;
        end else begin
          auto_cnt_d = auto_cnt_q - 16'd1;
        end
      end
      pwmc_pkg::MODE_STOP: begin
        if (!sw_i.down_sw && !sw_i.up_sw) begin
          mode_d = pwmc_pkg::MODE_IDLE;
        end
      end
      pwmc_pkg::MODE_SLEEP: begin
        if (sw_i.wake_req) begin
          motor_en_d = 1'b1;
          pwm_run_d  = 1'b1;
          mode_d     = pwmc_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    res_o.mode     = mode_d;
    res_o.down_cmp = down_cmp_d;
    res_o.up_cmp   = up_cmp_d;
    res_o.motor_en = motor_en_d;
    res_o.pwm_run  = pwm_run_d;
  end

  // The timeout counter is loaded only on entry to the automatic modes and is zero outside them.
  a_cnt_auto_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != pwmc_pkg::MODE_OPENING_AUTO && mode_q != pwmc_pkg::MODE_CLOSING_AUTO)
      |-> (auto_cnt_q == 16'd0))
    else $error("auto counter nonzero outside automatic modes");

  a_en_run_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motor_en_q == pwm_run_q)
    else $error("motor enable and PWM run flag disagree");

  a_sleep_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != pwmc_pkg::MODE_INIT) |-> (motor_en_q == (mode_q != pwmc_pkg::MODE_SLEEP)))
    else $error("motor enable does not follow sleep mode");

  a_auto_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == pwmc_pkg::MODE_OPENING_AUTO && mode_d == mode_q)
      |=> (auto_cnt_q == $past(auto_cnt_q) - 16'd1))
    else $error("auto counter did not count down");

endmodule

`default_nettype wire

[hw/rtl/pwmc_outq.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue between the mode machine and the output channel.
module pwmc_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire pwmc_pkg::pwmc_res_t data_i,
  output logic                    full_o,
  output logic                    valid_o,
  input  wire logic               pop_i,
  output pwmc_pkg::pwmc_res_t     data_o
);

  pwmc_pkg::pwmc_res_t slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overflow");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("result queue pointers disagree with count");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full result queue");

endmodule

`default_nettype wire

[hw/rtl/power_window_motor_control.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction carries
// in_i      sink       one control tick: down, up, auto, sleep and wake levels
// out_o     source     mode, down and up compare, motor enable, PWM running
// cfg_*     write      register index and data, no handshake, no read-back
//
// One tick is taken per clock cycle while in_i.ready is high; its result can
// leave on the next cycle. The mode machine computes its result combinationally;
// compare values come from a three-stage pipeline fed by the registers, so
// in_i.ready stays low after reset and after every register write while that
// pipeline refills. A two-entry result queue lets ticks keep arriving while
// out_o is stalled; otherwise in_i.ready drops only when both entries are held.
// Reset is asynchronous and active low and puts the registers at their defaults.
module power_window_motor_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pwmc_in_if.sink          in_i,
  pwmc_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  // Configuration registers.
  logic [15:0] period_q;
  logic [6:0]  floor_q;
  logic [6:0]  ceil_q;
  logic [6:0]  open_duty_q;
  logic [6:0]  close_duty_q;
  logic [15:0] timeout_q;

  // Holds off transactions until the compare pipeline reflects the registers.
  logic [pwmc_pkg::SettleW-1:0] settle_q;

  pwmc_pkg::pwmc_cmp_cfg_t cmp_cfg;
  pwmc_pkg::pwmc_sw_t      sw;
  pwmc_pkg::pwmc_res_t     res_next;
  pwmc_pkg::pwmc_res_t     res_head;
  logic [15:0]             open_cmp;
  logic [15:0]             close_cmp;
  logic                    q_full;
  logic                    q_valid;
  logic                    in_accept;
  logic                    out_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= pwmc_pkg::PeriodRst;
      floor_q      <= pwmc_pkg::FloorRst;
      ceil_q       <= pwmc_pkg::CeilRst;
      open_duty_q  <= pwmc_pkg::OpenRst;
      close_duty_q <= pwmc_pkg::CloseRst;
      timeout_q    <= pwmc_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwmc_pkg::REG_PERIOD:  period_q     <= cfg_wdata_i;
        pwmc_pkg::REG_FLOOR:   floor_q      <= cfg_wdata_i[6:0];
        pwmc_pkg::REG_CEIL:    ceil_q       <= cfg_wdata_i[6:0];
        pwmc_pkg::REG_OPEN:    open_duty_q  <= cfg_wdata_i[6:0];
        pwmc_pkg::REG_CLOSE:   close_duty_q <= cfg_wdata_i[6:0];
        pwmc_pkg::REG_TIMEOUT: timeout_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= pwmc_pkg::SettleW'(pwmc_pkg::SettleCycles);
    end else if (cfg_we_i) begin
      settle_q <= pwmc_pkg::SettleW'(pwmc_pkg::SettleCycles);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign cmp_cfg.period    = period_q;
  assign cmp_cfg.floor_pct = floor_q;
  assign cmp_cfg.ceil_pct  = ceil_q;

  // Both movement compares are kept ready; brake is the period itself.
  pwmc_cmp u_cmp_open (
    .clk_i  (clk_i),
    .cfg_i  (cmp_cfg),
    .duty_i (open_duty_q),
    .cmp_o  (open_cmp)
  );

  pwmc_cmp u_cmp_close (
    .clk_i  (clk_i),
    .cfg_i  (cmp_cfg),
    .duty_i (close_duty_q),
    .cmp_o  (close_cmp)
  );

  assign in_i.ready = !q_full && (settle_q == '0);
  assign in_accept  = in_i.valid && in_i.ready;

  assign sw.down_sw   = in_i.down_switch;
  assign sw.up_sw     = in_i.up_switch;
  assign sw.auto_sw   = in_i.auto_switch;
  assign sw.sleep_req = in_i.sleep_request;
  assign sw.wake_req  = in_i.wake_request;

  pwmc_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .sw_i           (sw),
    .brake_cmp_i    (period_q),
    .open_cmp_i     (open_cmp),
    .close_cmp_i    (close_cmp),
    .auto_timeout_i (timeout_q),
    .res_o          (res_next)
  );

  assign out_accept = q_valid && out_o.ready;

  pwmc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (res_next),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (out_accept),
    .data_o  (res_head)
  );

  assign out_o.valid            = q_valid;
  assign out_o.mode_code        = res_head.mode;
  assign out_o.down_compare_out = res_head.down_cmp;
  assign out_o.up_compare_out   = res_head.up_cmp;
  assign out_o.motor_enable_out = res_head.motor_en;
  assign out_o.pwm_running_out  = res_head.pwm_run;

  // No transaction may be taken while the compare pipeline refills.
  a_settle_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q != '0) |-> !in_accept)
    else $error("input taken while compare pipeline settles");

  a_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_i.ready)
    else $error("input ready right after a register write");

  a_out_follows_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !q_valid) |=> out_o.valid)
    else $error("result missing after accepted tick");

endmodule

`default_nettype wire
